// ===== src/vph_pkg.sv =====
// Package for the velocity-form PID heater controller.
// Holds field widths, register codes, the config and stage structs and the divide-by-five helper.
// No dependencies.
package vph_pkg;

  localparam int TEMP_W  = 10;
  localparam int GAIN_W  = 20;
  localparam int POWER_W = 8;
  localparam int ERR_W   = TEMP_W + 1;
  localparam int DD_W    = TEMP_W + 2;
  localparam int INDEX_W = 3;

  localparam logic [INDEX_W-1:0] REG_GAIN_P     = 3'd0;
  localparam logic [INDEX_W-1:0] REG_GAIN_I     = 3'd1;
  localparam logic [INDEX_W-1:0] REG_GAIN_D     = 3'd2;
  localparam logic [INDEX_W-1:0] REG_POWER_FLR  = 3'd3;
  localparam logic [INDEX_W-1:0] REG_POWER_CEIL = 3'd4;
  localparam logic [INDEX_W-1:0] REG_SOFT_TEMP  = 3'd5;

  localparam logic [GAIN_W-1:0]  RST_GAIN_P     = 20'd7680;
  localparam logic [GAIN_W-1:0]  RST_GAIN_I     = 20'd15360;
  localparam logic [GAIN_W-1:0]  RST_GAIN_D     = 20'd960;
  localparam logic [POWER_W-1:0] RST_POWER_FLR  = 8'd0;
  localparam logic [POWER_W-1:0] RST_POWER_CEIL = 8'd100;
  localparam logic [TEMP_W-1:0]  RST_SOFT_TEMP  = 10'd150;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [POWER_W-1:0] power_floor;
    logic [POWER_W-1:0] power_ceiling;
    logic [TEMP_W-1:0]  soft_start_temp;
  } vph_cfg_t;

  typedef struct packed {
    logic                    valid;
    logic signed [ERR_W-1:0] err;
    logic signed [ERR_W-1:0] dp;
    logic signed [DD_W-1:0]  dd;
    logic                    soft_hit;
  } vph_stage_t;

  // x/5 as (x*205)>>10, exact for every 8-bit x
  function automatic logic [POWER_W-1:0] div5(input logic [POWER_W-1:0] x);
    logic [17:0] prod;
    prod = 18'(x) * 18'd205;
    return prod[17:10];
  endfunction

endpackage

// ===== src/vph_in_if.sv =====
// Input channel of the heater controller: one temperature sample per beat.
// Depends on vph_pkg.
interface vph_in_if;
  import vph_pkg::*;

  logic              valid;
  logic              ready;
  logic [TEMP_W-1:0] measured_temp;
  logic [TEMP_W-1:0] target_temp;

  modport source(output valid, measured_temp, target_temp, input ready);
  modport sink(input valid, measured_temp, target_temp, output ready);
endinterface

// ===== src/vph_out_if.sv =====
// Output channel of the heater controller: one drive power value per beat.
// Depends on vph_pkg.
interface vph_out_if;
  import vph_pkg::*;

  logic               valid;
  logic               ready;
  logic [POWER_W-1:0] drive_power;
  logic               soft_start;

  modport source(output valid, drive_power, soft_start, input ready);
  modport sink(input valid, drive_power, soft_start, output ready);
endinterface

// ===== src/vph_regs.sv =====
// Configuration register file of the heater controller.
// Depends on vph_pkg.
module vph_regs (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [vph_pkg::INDEX_W-1:0] cfg_index,
  input  logic [vph_pkg::GAIN_W-1:0]  cfg_data,
  output vph_pkg::vph_cfg_t        cfg
);
  import vph_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p          <= RST_GAIN_P;
      cfg.gain_i          <= RST_GAIN_I;
      cfg.gain_d          <= RST_GAIN_D;
      cfg.power_floor     <= RST_POWER_FLR;
      cfg.power_ceiling   <= RST_POWER_CEIL;
      cfg.soft_start_temp <= RST_SOFT_TEMP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN_P:     cfg.gain_p          <= cfg_data;
        REG_GAIN_I:     cfg.gain_i          <= cfg_data;
        REG_GAIN_D:     cfg.gain_d          <= cfg_data;
        REG_POWER_FLR:  cfg.power_floor     <= cfg_data[POWER_W-1:0];
        REG_POWER_CEIL: cfg.power_ceiling   <= cfg_data[POWER_W-1:0];
        REG_SOFT_TEMP:  cfg.soft_start_temp <= cfg_data[TEMP_W-1:0];
        default: ;
      endcase
    end
  end
endmodule

// ===== src/vph_front.sv =====
// Input stage: temperature history, differences and soft-start decision.
// Depends on vph_pkg and vph_in_if.
module vph_front (
  input  logic                clk,
  input  logic                rst,
  input  vph_pkg::vph_cfg_t   cfg,
  vph_in_if.sink              sample,
  input  logic                stage_ready,
  output vph_pkg::vph_stage_t stage
);
  import vph_pkg::*;

  logic [TEMP_W-1:0] prev_temp;
  logic [TEMP_W-1:0] prev_prev_temp;
  logic [TEMP_W-1:0] p_seed;
  logic [TEMP_W-1:0] pp_seed;
  logic              seed;
  logic              accept;
  vph_stage_t        stage_next;

  assign sample.ready = !stage.valid || stage_ready;
  assign accept       = sample.valid && sample.ready;

  always_comb begin
    seed    = (prev_temp == '0) || (prev_prev_temp == '0);
    p_seed  = seed ? sample.measured_temp : prev_temp;
    pp_seed = seed ? sample.measured_temp : prev_prev_temp;
    stage_next.valid = 1'b1;
    stage_next.err   = ERR_W'(sample.target_temp) - ERR_W'(sample.measured_temp);
    stage_next.dp    = ERR_W'(p_seed) - ERR_W'(sample.measured_temp);
    stage_next.dd    = DD_W'({p_seed, 1'b0}) - DD_W'(sample.measured_temp) - DD_W'(pp_seed);
    stage_next.soft_hit = (sample.measured_temp < cfg.soft_start_temp) &&
                          (sample.measured_temp < sample.target_temp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_temp      <= '0;
      prev_prev_temp <= '0;
      stage.valid    <= 1'b0;
    end else if (accept) begin
      prev_prev_temp <= p_seed;
      prev_temp      <= sample.measured_temp;
      stage          <= stage_next;
    end else if (stage_ready) begin
      stage.valid    <= 1'b0;
    end
  end
endmodule

// ===== src/vph_core.sv =====
// PID update: gain products, accumulator sum, truncation, clamp, soft-start override and result register.
// Depends on vph_pkg and vph_out_if.
module vph_core #(
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  vph_pkg::vph_cfg_t   cfg,
  input  vph_pkg::vph_stage_t stage,
  output logic                stage_ready,
  vph_out_if.source           result
);
  import vph_pkg::*;

  localparam int PROD_W = GAIN_W + 1 + DD_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam logic signed [SUM_W-1:0] TRUNC_BIAS =
    SUM_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

  logic [POWER_W-1:0]      power_accum;
  logic [POWER_W-1:0]      power_accum_next;
  logic                    take;
  logic signed [GAIN_W:0]  gp, gi, gd;
  logic signed [DD_W-1:0]  dp_x, err_x;
  logic signed [PROD_W-1:0] prod_p, prod_i, prod_d;
  logic signed [SUM_W-1:0] acc_term, sum, sum_b, whole, ceil_s, floor_s;

  assign stage_ready = !result.valid || result.ready;
  assign take        = stage.valid && stage_ready;

  always_comb begin
    gp      = {1'b0, cfg.gain_p};
    gi      = {1'b0, cfg.gain_i};
    gd      = {1'b0, cfg.gain_d};
    dp_x    = DD_W'(stage.dp);
    err_x   = DD_W'(stage.err);
    prod_p  = gp * dp_x;
    prod_i  = gi * err_x;
    prod_d  = gd * stage.dd;
    acc_term = SUM_W'(power_accum) <<< GAIN_FRAC_BITS;
    sum     = acc_term + SUM_W'(prod_p) + SUM_W'(prod_i) + SUM_W'(prod_d);
    // bias negative sums so the shift truncates toward zero
    sum_b   = sum[SUM_W-1] ? sum + TRUNC_BIAS : sum;
    whole   = sum_b >>> GAIN_FRAC_BITS;
    ceil_s  = SUM_W'(cfg.power_ceiling);
    floor_s = SUM_W'(cfg.power_floor);
    if (whole > ceil_s) begin
      power_accum_next = cfg.power_ceiling;
    end else if (whole < floor_s) begin
      power_accum_next = cfg.power_floor;
    end else begin
      power_accum_next = whole[POWER_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      power_accum  <= '0;
      result.valid <= 1'b0;
    end else if (take) begin
      power_accum  <= power_accum_next;
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.drive_power <= stage.soft_hit ? div5(cfg.power_ceiling) : power_accum_next;
      result.soft_start  <= stage.soft_hit;
    end
  end

`ifndef NO_ASSERTIONS
  a_take_fills: assert property (@(posedge clk) disable iff (rst) take |=> result.valid)
    else $error("result register not loaded after take");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |-> !take)
    else $error("stalled result overwritten");
  a_accum_bound: assert property (@(posedge clk) disable iff (rst)
    take |=> (power_accum <= $past(cfg.power_ceiling) ||
              power_accum == $past(cfg.power_floor)))
    else $error("accumulator outside power limits");
`endif
endmodule

// ===== src/velocity_pid_heater_control.sv =====
// Top level of the velocity-form PID heater controller.
// Depends on vph_pkg, vph_in_if, vph_out_if, vph_regs, vph_front and vph_core.
//
//   channel  dir  beat contents                     handshake
//   sample   in   measured_temp, target_temp        valid/ready
//   result   out  drive_power, soft_start           valid/ready
//   cfg      in   cfg_index, cfg_data               cfg_we, no back-pressure
//
// One sample per cycle sustained while results are taken; a sample beat is registered
// in the input stage and then in the result register, from which its result is offered.
// The rate is set by the accumulator loop, closed through the power_accum register, the
// core's three parallel gain multipliers and the sum, truncate and clamp that follow.
// Reset clears history, accumulator and both valid flags and loads register defaults.
// A stalled result holds in the result register while one more sample waits in the
// input stage; the sample channel drops ready only when both are full.
module velocity_pid_heater_control #(
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [vph_pkg::INDEX_W-1:0] cfg_index,
  input  logic [vph_pkg::GAIN_W-1:0]  cfg_data,
  vph_in_if.sink                      sample,
  vph_out_if.source                   result
);
  import vph_pkg::*;

  vph_cfg_t   cfg;
  vph_stage_t stage;
  logic       stage_ready;

  // Registers: gains, power limits and soft-start threshold.
  vph_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input stage: seed and advance the temperature history, form the
  // error, first and second differences, decide soft start.
  vph_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .sample      (sample),
    .stage_ready (stage_ready),
    .stage       (stage)
  );

  // Core: weight the error and differences, add to the shifted accumulator,
  // truncate toward zero, clamp, and load the result register (or the soft-start power).
  vph_core #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .stage       (stage),
    .stage_ready (stage_ready),
    .result      (result)
  );
endmodule
